// ----- rtl/gralloc_pkg.sv -----
// ----------------------------------------------------------------------------
// Grant reference allocator package
// Sizes, operation and status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package gralloc_pkg;

	localparam int ENTRIES  = 2048;
	localparam int RESERVED = 8;
	localparam int W        = 12;
	localparam int IDX_W    = $clog2(ENTRIES);

	localparam logic [W-1:0] END_REF     = W'(ENTRIES + 1);
	localparam logic [W-1:0] ENTRIES_REF = W'(ENTRIES);
	localparam logic [W-1:0] RESET_HEAD  = W'(RESERVED);
	localparam logic [W-1:0] RESET_TOTAL = W'(ENTRIES - RESERVED);

	localparam logic [2:0] MODE_ALLOC   = 3'd0;
	localparam logic [2:0] MODE_FREE1   = 3'd1;
	localparam logic [2:0] MODE_FREECH  = 3'd2;
	localparam logic [2:0] MODE_CLAIM   = 3'd3;
	localparam logic [2:0] MODE_RELEASE = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic clr_en;
		logic load_item;
		logic start;
		logic rd;
		logic link;
		logic wr;
		logic res_load;
	} gralloc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_alloc;
		logic is_free1;
		logic is_freech;
		logic is_claim;
		logic is_release;
		logic alloc_fail;
		logic ref_ok;
		logic claim_end;
		logic walk_more;
		logic link_end;
		logic clr_last;
		logic out_busy;
	} gralloc_stat_t;

endpackage

// ----- rtl/gralloc_dp.sv -----
// ----------------------------------------------------------------------------
// Grant reference allocator datapath
// Link memory, free head and count, walk registers and the result register.
// ----------------------------------------------------------------------------
module gralloc_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gralloc_pkg::gralloc_cmd_t  cmd,
	output gralloc_pkg::gralloc_stat_t stat,
	input  logic [2:0]                 mode,
	input  logic [gralloc_pkg::W-1:0]  count,
	input  logic [gralloc_pkg::W-1:0]  ref_req,
	input  logic [gralloc_pkg::W-1:0]  list_head,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 status,
	output logic [gralloc_pkg::W-1:0]  ref_out,
	output logic [gralloc_pkg::W-1:0]  new_list_head,
	output logic [gralloc_pkg::W-1:0]  free_count
);
	import gralloc_pkg::*;

	logic [W-1:0]     link_mem [ENTRIES];
	logic [W-1:0]     rdata_q;
	logic [IDX_W-1:0] clr_q;

	logic [2:0]   mode_q;
	logic [W-1:0] count_q, ref_q, lhead_q;
	logic [W-1:0] cur_q, walk_q;
	logic [W-1:0] head_q, total_q;
	logic [1:0]   res_status_q;
	logic [W-1:0] res_ref_q, res_nlh_q;
	logic         out_valid_q;
	logic [1:0]   out_status_q;
	logic [W-1:0] out_ref_q, out_nlh_q, out_count_q;

	logic             cur_ok;
	logic [W-1:0]     link_val;
	logic [W:0]       add_sum;
	logic [W-1:0]     add_sat;
	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [W-1:0]     wdata;

	assign cur_ok   = cur_q < ENTRIES_REF;
	assign link_val = cur_ok ? rdata_q : END_REF;

	assign stat.is_alloc   = mode_q == MODE_ALLOC;
	assign stat.is_free1   = mode_q == MODE_FREE1;
	assign stat.is_freech  = mode_q == MODE_FREECH;
	assign stat.is_claim   = mode_q == MODE_CLAIM;
	assign stat.is_release = mode_q == MODE_RELEASE;
	assign stat.alloc_fail = (count_q == '0) || (count_q > total_q);
	assign stat.ref_ok     = ref_q < ENTRIES_REF;
	assign stat.claim_end  = lhead_q == END_REF;
	assign stat.walk_more  = stat.is_alloc ? (walk_q < count_q)
	                                       : (walk_q != W'(ENTRIES - 1));
	assign stat.link_end   = link_val >= ENTRIES_REF;
	assign stat.clr_last   = clr_q == IDX_W'(ENTRIES - 1);
	assign stat.out_busy   = out_valid_q & ~out_ready;

	// saturating add for frees: one entry or a walked chain
	assign add_sum = {1'b0, total_q} + {1'b0, (stat.is_free1 ? W'(1) : walk_q)};
	assign add_sat = (add_sum > {1'b0, ENTRIES_REF}) ? ENTRIES_REF : add_sum[W-1:0];

	always_comb begin
		we    = 1'b0;
		waddr = cur_q[IDX_W-1:0];
		wdata = END_REF;
		if (cmd.clr_en) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = W'(clr_q) + W'(1);
		end else if (cmd.wr) begin
			if (stat.is_alloc) begin
				we = cur_ok;
			end else if (stat.is_freech) begin
				we    = 1'b1;
				wdata = head_q;
			end else if (stat.is_free1) begin
				we    = 1'b1;
				waddr = ref_q[IDX_W-1:0];
				wdata = head_q;
			end else if (stat.is_release) begin
				we    = 1'b1;
				waddr = ref_q[IDX_W-1:0];
				wdata = lhead_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			link_mem[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= link_mem[cur_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			head_q      <= RESET_HEAD;
			total_q     <= RESET_TOTAL;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_en) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cmd.link && stat.is_alloc && !stat.walk_more) begin
				head_q <= link_val;
			end
			if (cmd.wr) begin
				if (stat.is_alloc) begin
					total_q <= total_q - count_q;
				end else if (stat.is_free1 || stat.is_freech) begin
					head_q  <= ref_q;
					total_q <= add_sat;
				end
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mode_q  <= mode;
			count_q <= count;
			ref_q   <= ref_req;
			lhead_q <= list_head;
		end
		if (cmd.start) begin
			walk_q       <= W'(1);
			res_status_q <= ST_OK;
			res_ref_q    <= END_REF;
			res_nlh_q    <= lhead_q;
			cur_q        <= lhead_q;
			if (stat.is_alloc) begin
				cur_q <= head_q;
				if (stat.alloc_fail) begin
					res_status_q <= ST_NOFREE;
				end else begin
					res_ref_q <= head_q;
				end
			end else if (stat.is_freech) begin
				cur_q <= ref_q;
			end else if (stat.is_claim) begin
				if (stat.claim_end) begin
					res_status_q <= ST_EMPTY;
					res_nlh_q    <= END_REF;
				end else begin
					res_ref_q <= lhead_q;
				end
			end
		end
		if (cmd.link) begin
			if (stat.is_claim) begin
				res_nlh_q <= link_val;
			end else if (stat.is_alloc) begin
				if (stat.walk_more) begin
					cur_q  <= link_val;
					walk_q <= walk_q + W'(1);
				end
			end else if (!stat.link_end) begin
				cur_q  <= link_val;
				walk_q <= walk_q + W'(1);
			end
		end
		if (cmd.wr && stat.is_release) begin
			res_nlh_q <= ref_q;
		end
		if (cmd.res_load) begin
			out_status_q <= res_status_q;
			out_ref_q    <= res_ref_q;
			out_nlh_q    <= res_nlh_q;
			out_count_q  <= total_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign ref_out       = out_ref_q;
	assign new_list_head = out_nlh_q;
	assign free_count    = out_count_q;

endmodule

// ----- rtl/gralloc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Grant reference allocator controller
// Sequences the clearing pass, the link walks, the final write and the result.
// ----------------------------------------------------------------------------
module gralloc_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  gralloc_pkg::gralloc_stat_t stat,
	output gralloc_pkg::gralloc_cmd_t  cmd
);
	import gralloc_pkg::*;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_EVAL  = 7'b0000100,
		S_RD    = 7'b0001000,
		S_LINK  = 7'b0010000,
		S_WR    = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.start = 1'b1;
				priority if (stat.is_alloc) begin
					state_d = stat.alloc_fail ? S_DONE : S_RD;
				end else if (stat.is_freech) begin
					state_d = stat.ref_ok ? S_RD : S_DONE;
				end else if (stat.is_claim) begin
					state_d = stat.claim_end ? S_DONE : S_RD;
				end else if (stat.is_free1 || stat.is_release) begin
					state_d = stat.ref_ok ? S_WR : S_DONE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_LINK;
			end
			S_LINK: begin
				cmd.link = 1'b1;
				priority if (stat.is_claim) begin
					state_d = S_DONE;
				end else if (stat.is_alloc) begin
					state_d = stat.walk_more ? S_RD : S_WR;
				end else begin
					// chain free: stop at an end link or after a full pool of steps
					state_d = (stat.link_end || !stat.walk_more) ? S_WR : S_RD;
				end
			end
			S_WR: begin
				cmd.wr  = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/grant_ref_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// Grant reference free-list allocator
// Keeps free reference numbers on a list linked through a link memory.
// After reset a clearing pass loads each link with its index plus one; no
// item is accepted until it ends. One item at a time, on the single-port link
// memory: an item is evaluated, walks its list by a read and a link step per
// entry if it needs a walk, makes its final write if it has one, then loads the result.
// The result register lets the next item enter while a result waits.
// ----------------------------------------------------------------------------
module grant_ref_free_list_allocator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [2:0]                mode,
	input  logic [gralloc_pkg::W-1:0] count,
	input  logic [gralloc_pkg::W-1:0] ref_req,
	input  logic [gralloc_pkg::W-1:0] list_head,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                status,
	output logic [gralloc_pkg::W-1:0] ref_out,
	output logic [gralloc_pkg::W-1:0] new_list_head,
	output logic [gralloc_pkg::W-1:0] free_count
);
	import gralloc_pkg::*;

	gralloc_cmd_t  cmd;
	gralloc_stat_t stat;

	gralloc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gralloc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.mode          (mode),
		.count         (count),
		.ref_req       (ref_req),
		.list_head     (list_head),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.ref_out       (ref_out),
		.new_list_head (new_list_head),
		.free_count    (free_count)
	);

endmodule

// ----- sim/tb_grant_ref_free_list_allocator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Grant reference free-list allocator testbench
// Keeps a shadow copy of the link memory, free head and free count. It queues
// a directed opening and then mostly well-formed random traffic, with a
// little noise mixed in. Each item carries its predicted result. Results are
// checked field by field in order, under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_grant_ref_free_list_allocator;
	import gralloc_pkg::*;

	localparam logic [2:0] MODE_NOP_5 = 3'd5;
	localparam logic [2:0] MODE_NOP_7 = 3'd7;
	localparam int RANDOM_ITEMS = 1250;
	localparam int CALM_TAIL    = 120;

	typedef struct packed {
		logic [1:0]   status;
		logic [W-1:0] ref_out;
		logic [W-1:0] new_head;
		logic [W-1:0] total;
	} pool_result_t;

	typedef struct packed {
		logic [2:0]   mode;
		logic [W-1:0] count;
		logic [W-1:0] ref_req;
		logic [W-1:0] list_head;
		pool_result_t res;
	} pool_op_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         in_valid = 1'b0;
	logic         in_ready;
	logic [2:0]   mode = '0;
	logic [W-1:0] count = '0;
	logic [W-1:0] ref_req = '0;
	logic [W-1:0] list_head = '0;
	logic         out_valid;
	logic         out_ready = 1'b0;
	logic [1:0]   status;
	logic [W-1:0] ref_out;
	logic [W-1:0] new_list_head;
	logic [W-1:0] free_count;

	grant_ref_free_list_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.count        (count),
		.ref_req      (ref_req),
		.list_head    (list_head),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.ref_out      (ref_out),
		.new_list_head(new_list_head),
		.free_count   (free_count)
	);

	// shadow pool
	logic [W-1:0] link_mem [0:ENTRIES-1];
	logic [W-1:0] pool_head;
	logic [W-1:0] pool_total;

	pool_op_t     ops_to_send[$];
	pool_result_t results_due[$];
	pool_op_t     cur_op;

	int n_total;
	int sent_items = 0;
	int received = 0;
	int mismatches = 0;
	int gap_left = 0;
	int stall_left = 0;
	int per_mode [0:7];
	int refused = 0;
	int empty_claims = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [W-1:0] link_at(input logic [W-1:0] idx);
		return (idx >= ENTRIES_REF) ? END_REF : link_mem[idx[IDX_W-1:0]];
	endfunction

	function automatic logic [W-1:0] any_ref();
		return W'($urandom_range(0, ENTRIES + 1));
	endfunction

	function automatic logic [W-1:0] any_count();
		return W'($urandom_range(0, ENTRIES));
	endfunction

	// Advance the shadow pool by one operation and queue the item with its result.
	task automatic pool_step(input logic [2:0] m, input logic [W-1:0] cnt,
			input logic [W-1:0] rq, input logic [W-1:0] lh, output pool_result_t r);
		pool_op_t     op;
		logic [W-1:0] cur;
		int           k;
		int           freed;
		int           total_next;
		freed = 0;
		r.status = ST_OK;
		r.ref_out = END_REF;
		r.new_head = lh;
		case (m)
			MODE_ALLOC: begin
				if (cnt == 0 || cnt > pool_total) begin
					r.status = ST_NOFREE;
				end else begin
					cur = pool_head;
					for (k = 1; k < cnt; k++)
						cur = link_at(cur);
					r.ref_out = pool_head;
					pool_head = link_at(cur);
					if (cur < ENTRIES_REF)
						link_mem[cur[IDX_W-1:0]] = END_REF;
					pool_total = pool_total - cnt;
				end
			end
			MODE_FREE1: begin
				if (rq < ENTRIES_REF) begin
					link_mem[rq[IDX_W-1:0]] = pool_head;
					pool_head = rq;
					freed = 1;
				end
			end
			MODE_FREECH: begin
				if (rq < ENTRIES_REF) begin
					cur = rq;
					freed = 1;
					// bounded walk, so a cyclic chain still ends
					while (freed < ENTRIES && link_at(cur) < ENTRIES_REF) begin
						cur = link_at(cur);
						freed++;
					end
					link_mem[cur[IDX_W-1:0]] = pool_head;
					pool_head = rq;
				end
			end
			MODE_CLAIM: begin
				if (lh == END_REF) begin
					r.status = ST_EMPTY;
					r.new_head = END_REF;
				end else begin
					r.ref_out = lh;
					r.new_head = link_at(lh);
				end
			end
			MODE_RELEASE: begin
				if (rq < ENTRIES_REF) begin
					link_mem[rq[IDX_W-1:0]] = lh;
					r.new_head = rq;
				end
			end
			default: begin
			end
		endcase
		if (freed != 0) begin
			total_next = int'(pool_total) + freed;
			pool_total = (total_next > ENTRIES) ? ENTRIES_REF : W'(total_next);
		end
		r.total = pool_total;
		per_mode[m]++;
		if (r.status == ST_NOFREE)
			refused++;
		if (r.status == ST_EMPTY)
			empty_claims++;
		op.mode = m;
		op.count = cnt;
		op.ref_req = rq;
		op.list_head = lh;
		op.res = r;
		ops_to_send.push_back(op);
	endtask

	task automatic compare_field(input string name, input logic [W-1:0] want,
			input logic [W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode <= '0;
			count <= '0;
			ref_req <= '0;
			list_head <= '0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				results_due.push_back(cur_op.res);
				sent_items++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (sent_items < n_total - CALM_TAIL && $urandom_range(0, 5) == 0) begin
					gap_left <= $urandom_range(0, 16);
					in_valid <= 1'b0;
				end else if (ops_to_send.size() != 0) begin
					cur_op = ops_to_send.pop_front();
					mode <= cur_op.mode;
					count <= cur_op.count;
					ref_req <= cur_op.ref_req;
					list_head <= cur_op.list_head;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$error("result with nothing outstanding: status %0d ref_out %0d",
						status, ref_out);
					mismatches++;
				end else begin
					compare_field("status", W'(results_due[0].status), W'(status));
					compare_field("ref_out", results_due[0].ref_out, ref_out);
					compare_field("new_list_head", results_due[0].new_head, new_list_head);
					compare_field("free_count", results_due[0].total, free_count);
					void'(results_due.pop_front());
				end
				received++;
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (received < n_total - CALM_TAIL && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 16);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		pool_result_t r;
		logic [W-1:0] ent_a;
		logic [W-1:0] chain_b;
		logic [W-1:0] whole_pool;
		logic [W-1:0] priv_head;
		logic [W-1:0] rq;
		logic [W-1:0] held_chains[$];
		logic [W-1:0] held_singles[$];
		int i;
		int pick;
		int sel;
		int idx;
		int cnt;
		int drain;

		for (i = 0; i < ENTRIES; i++)
			link_mem[IDX_W'(i)] = W'(i + 1);
		pool_head = RESET_HEAD;
		pool_total = RESET_TOTAL;
		for (i = 0; i < 8; i++)
			per_mode[3'(i)] = 0;
		priv_head = END_REF;

		// directed opening
		pool_step(MODE_ALLOC, '0, any_ref(), any_ref(), r);
		pool_step(MODE_ALLOC, ENTRIES_REF, any_ref(), any_ref(), r);
		pool_step(MODE_ALLOC, W'(1), any_ref(), any_ref(), r);
		ent_a = r.ref_out;
		pool_step(MODE_ALLOC, W'(3), any_ref(), any_ref(), r);
		chain_b = r.ref_out;
		pool_step(MODE_CLAIM, any_count(), any_ref(), END_REF, r);
		pool_step(MODE_RELEASE, any_count(), ENTRIES_REF, END_REF, r);
		pool_step(MODE_RELEASE, any_count(), ent_a, END_REF, r);
		pool_step(MODE_CLAIM, any_count(), any_ref(), ENTRIES_REF, r);
		pool_step(MODE_CLAIM, any_count(), any_ref(), ent_a, r);
		pool_step(MODE_FREE1, any_count(), END_REF, any_ref(), r);
		pool_step(MODE_FREECH, any_count(), END_REF, any_ref(), r);
		pool_step(MODE_FREECH, any_count(), ENTRIES_REF, any_ref(), r);
		pool_step(MODE_FREECH, any_count(), chain_b, any_ref(), r);
		// self-linked entry: the chain walk must stop on its step bound
		pool_step(MODE_RELEASE, any_count(), ent_a, ent_a, r);
		pool_step(MODE_FREECH, any_count(), ent_a, any_ref(), r);
		// reserved entry onto a saturated count
		pool_step(MODE_FREE1, any_count(), '0, '0, r);
		pool_step(MODE_NOP_5, any_count(), any_ref(), any_ref(), r);
		pool_step(MODE_NOP_7, any_count(), any_ref(), any_ref(), r);
		// count is inflated, so this walks past the end of the list
		pool_step(MODE_ALLOC, pool_total, any_ref(), any_ref(), r);
		whole_pool = r.ref_out;
		pool_step(MODE_ALLOC, W'(1), any_ref(), any_ref(), r);
		pool_step(MODE_CLAIM, any_count(), any_ref(), '0, r);
		// hand everything back; the count is exact again afterwards
		pool_step(MODE_FREECH, any_count(), whole_pool, any_ref(), r);

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ENTRIES) :
					$urandom_range(0, 16);
				pool_step(3'($urandom_range(0, 4)), W'(cnt), any_ref(), any_ref(), r);
			end else begin
				pick = (held_chains.size() + held_singles.size() > 48) ?
					$urandom_range(30, 99) : $urandom_range(0, 99);
				if (pick >= 30 && pick < 48 && held_chains.size() == 0)
					pick = 0;
				if (pick >= 48 && pick < 80 && held_singles.size() == 0)
					pick = 0;
				if (pick < 30) begin
					sel = $urandom_range(0, 99);
					if (sel < 70)
						cnt = $urandom_range(1, 4);
					else if (sel < 92)
						cnt = $urandom_range(5, 24);
					else if (sel < 97)
						cnt = $urandom_range(25, 200);
					else if (sel < 98)
						cnt = 0;
					else if (sel < 99) begin
						cnt = int'(pool_total) + $urandom_range(1, 8);
						if (cnt > ENTRIES)
							cnt = 0;
					end else
						cnt = $urandom_range(201, 900);
					pool_step(MODE_ALLOC, W'(cnt), any_ref(), any_ref(), r);
					if (r.status == ST_OK) begin
						if (cnt == 1)
							held_singles.push_back(r.ref_out);
						else
							held_chains.push_back(r.ref_out);
					end
				end else if (pick < 48) begin
					idx = $urandom_range(0, held_chains.size() - 1);
					rq = held_chains[idx];
					held_chains.delete(idx);
					pool_step(MODE_FREECH, any_count(), rq, any_ref(), r);
				end else if (pick < 80) begin
					idx = $urandom_range(0, held_singles.size() - 1);
					rq = held_singles[idx];
					held_singles.delete(idx);
					if (pick < 62) begin
						pool_step(MODE_FREE1, any_count(), rq, any_ref(), r);
					end else begin
						pool_step(MODE_RELEASE, any_count(), rq, priv_head, r);
						priv_head = r.new_head;
					end
				end else begin
					pool_step(MODE_CLAIM, any_count(), any_ref(), priv_head, r);
					priv_head = r.new_head;
					if (r.status == ST_OK && r.ref_out < ENTRIES_REF)
						held_singles.push_back(r.ref_out);
				end
			end
		end
		n_total = ops_to_send.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (sent_items < n_total)
			@(posedge clk);
		drain = 0;
		while (results_due.size() != 0 && drain < 50000) begin
			@(posedge clk);
			drain++;
		end
		if (results_due.size() != 0) begin
			$error("%0d results never arrived", results_due.size());
			mismatches++;
		end
		repeat (40) @(posedge clk);

		$display("Ran %0d items: %0d allocations (%0d refused), %0d single frees, %0d chain frees,",
			n_total, per_mode[0], refused, per_mode[1], per_mode[2]);
		$display("  %0d claims (%0d on an empty chain), %0d releases, %0d spare modes; %0d checked",
			per_mode[3], empty_claims, per_mode[4], per_mode[5] + per_mode[7], received);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#200000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/gralloc_pkg.sv
rtl/gralloc_dp.sv
rtl/gralloc_ctrl.sv
rtl/grant_ref_free_list_allocator.sv
sim/tb_grant_ref_free_list_allocator.sv
